### src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/shabs_pkg.sv
// shared types and constants of the sha-256 byte stream hasher
package shabs_pkg;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed
    {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
        logic [31:0] digest_word5;
        logic [31:0] digest_word6;
        logic [31:0] digest_word7;
    } digest_item_t;

    typedef logic [7:0][31:0] hash_words_t;

    typedef struct packed
    {
        logic       push;
        logic [7:0] data;
        logic       init;
    } core_cmd_t;

    typedef struct packed
    {
        logic        busy;
        logic [5:0]  fill;
        hash_words_t hash;
    } core_stat_t;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [5:0] PAD_LEN_START = 6'd56;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

### src/shabs_core.sv
// block buffer, rolling message schedule and one-round-per-cycle compression unit
module shabs_core
    import shabs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_cmd_t  cmd,
    output core_stat_t stat
);

    typedef enum logic [2:0]
    {
        CS_LOAD  = 3'b001,
        CS_ROUND = 3'b010,
        CS_FINAL = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [5:0]   round_reg, round_next;
    logic [511:0] blk_reg, blk_next;
    hash_words_t  hash_reg, hash_next;
    hash_words_t  v_reg, v_next;

    logic [31:0] w_cur, w_new, t1, t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // schedule window: top word is w[t], word k below it is w[t+k]
    always_comb
    begin
        logic [31:0] w1, w9, w14, sg0, sg1;
        w_cur = blk_reg[511:480];
        w1    = blk_reg[479:448];
        w9    = blk_reg[223:192];
        w14   = blk_reg[63:32];
        sg0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        sg1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        w_new = w_cur + sg0 + w9 + sg1;
    end

    always_comb
    begin
        logic [31:0] bs0, bs1, ch, maj;
        bs1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        bs0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + bs1 + ch + ROUND_K[round_reg] + w_cur;
        t2  = bs0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        blk_next   = blk_reg;
        hash_next  = hash_reg;
        v_next     = v_reg;
        unique case (state_reg)
            CS_LOAD:
            begin
                if (cmd.init)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_next[i] = HASH_IV[i];
                    end
                    fill_next = '0;
                end
                else if (cmd.push)
                begin
                    blk_next  = {blk_reg[503:0], cmd.data};
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        v_next     = hash_reg;
                        round_next = '0;
                        state_next = CS_ROUND;
                    end
                end
            end
            CS_ROUND:
            begin
                blk_next = {blk_reg[479:0], w_new};
                v_next   = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = CS_FINAL;
                end
            end
            CS_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                state_next = CS_LOAD;
            end
            default:
            begin
                state_next = CS_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_LOAD;
            fill_reg  <= '0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= HASH_IV[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        v_reg   <= v_next;
    end

    assign stat.busy = (state_reg != CS_LOAD);
    assign stat.fill = fill_reg;
    assign stat.hash = hash_reg;

`include "assert_macros.svh"

    `ASSERT_SAME(a_push_when_loading, cmd.push || cmd.init, state_reg == CS_LOAD)
    `ASSERT_NEXT(a_last_round_final, (state_reg == CS_ROUND) && (round_reg == 6'd63), state_reg == CS_FINAL)
    `ASSERT_NEXT(a_final_fill_clear, state_reg == CS_FINAL, (state_reg == CS_LOAD) && (fill_reg == 6'd0))

endmodule

### src/sha256_byte_stream_hasher.sv
// top level: byte intake, padding sequencer, length field and digest register
//
//  channel   beat                      handshake
//  msg       data_byte + flags         msg_valid / msg_ready
//  digest    eight 32-bit hash words   digest_valid / digest_ready
//
// one byte beat a cycle while msg_ready is high; the 64th byte of a block holds
// msg_ready low for the 64 rounds on the shared round unit plus the hash update
// an end beat runs the padding, pad bytes pushed while the core is not busy, through
// one or two compressions, then loads the digest register
// a waiting digest does not hold back the next message's bytes
// reset loads the initial hash values and clears fill and byte count
module sha256_byte_stream_hasher
    import shabs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_ready,
    input  msg_item_t    msg,
    output logic         digest_valid,
    input  logic         digest_ready,
    output digest_item_t digest
);

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_MARK  = 5'b00010,
        ST_ZERO  = 5'b00100,
        ST_LEN   = 5'b01000,
        ST_WAIT  = 5'b10000
    } seq_state_t;

    seq_state_t   state_reg, state_next;
    logic [60:0]  count_reg, count_next;
    logic [2:0]   len_idx_reg, len_idx_next;
    logic         digest_valid_reg, digest_valid_next;
    digest_item_t digest_reg, digest_next;

    core_cmd_t  cmd;
    core_stat_t stat;
    logic [63:0] bit_len;
    logic        accept;

    shabs_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign bit_len   = {count_reg, 3'b000};
    assign msg_ready = (state_reg == ST_IDLE) && !stat.busy;
    assign accept    = msg_valid && msg_ready;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        len_idx_next      = len_idx_reg;
        digest_valid_next = digest_valid_reg;
        digest_next       = digest_reg;
        cmd.push          = 1'b0;
        cmd.data          = msg.data_byte;
        cmd.init          = 1'b0;

        if (digest_valid_reg && digest_ready)
        begin
            digest_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (msg.byte_present)
                    begin
                        cmd.push   = 1'b1;
                        count_next = count_reg + 61'd1;
                    end
                    if (msg.end_of_message)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                if (!stat.busy)
                begin
                    cmd.push   = 1'b1;
                    cmd.data   = PAD_MARK;
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (!stat.busy)
                begin
                    if (stat.fill == PAD_LEN_START)
                    begin
                        len_idx_next = '0;
                        state_next   = ST_LEN;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.data = '0;
                    end
                end
            end
            ST_LEN:
            begin
                // big-endian bit length, most significant byte first
                cmd.push     = 1'b1;
                cmd.data     = bit_len[{~len_idx_reg, 3'b000} +: 8];
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == 3'd7)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!stat.busy && (!digest_valid_reg || digest_ready))
                begin
                    digest_next.digest_word0 = stat.hash[0];
                    digest_next.digest_word1 = stat.hash[1];
                    digest_next.digest_word2 = stat.hash[2];
                    digest_next.digest_word3 = stat.hash[3];
                    digest_next.digest_word4 = stat.hash[4];
                    digest_next.digest_word5 = stat.hash[5];
                    digest_next.digest_word6 = stat.hash[6];
                    digest_next.digest_word7 = stat.hash[7];
                    digest_valid_next        = 1'b1;
                    cmd.init                 = 1'b1;
                    count_next               = '0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            len_idx_reg      <= '0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            len_idx_reg      <= len_idx_next;
            digest_valid_reg <= digest_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
    end

    assign digest_valid = digest_valid_reg;
    assign digest       = digest_reg;

`include "assert_macros.svh"

    `ASSERT_SAME(a_busy_blocks_intake, stat.busy, !msg_ready)
    `ASSERT_SAME(a_len_in_tail, state_reg == ST_LEN, stat.fill[5:3] == 3'b111)
    `ASSERT_SAME(a_digest_from_wait, $rose(digest_valid_reg), $past(state_reg == ST_WAIT))

endmodule
